@@ rtl/dmrd_pkg.sv @@
// Package for the dual motor ramp drive.
// Holds the default widths, command and class codes, register indexes and the result struct.
// No dependencies.
`timescale 1ns / 1ps

package dmrd_pkg;

  localparam int DUTY_BITS_DEF     = 12;
  localparam int INTERVAL_BITS_DEF = 16;

  localparam int OUT_DUTY_W  = 12;
  localparam int SPEED_W     = 16;
  localparam int FUNC_W      = 2;
  localparam int CLASS_W     = 3;
  localparam int CFG_IDX_W   = 2;

  localparam int MAX_DUTY_RESET      = 255;
  localparam int RAMP_STEP_RESET     = 5;
  localparam int RAMP_INTERVAL_RESET = 20;

  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL = 2'd2;

  localparam logic [CLASS_W-1:0] CLASS_STOP     = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_FORWARD  = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_BACKWARD = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_LEFT     = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_RIGHT    = 3'd4;
  localparam logic [CLASS_W-1:0] CLASS_OTHER    = 3'd5;

  typedef struct packed {
    logic [OUT_DUTY_W-1:0] left_fwd_duty;
    logic [OUT_DUTY_W-1:0] left_rev_duty;
    logic [OUT_DUTY_W-1:0] right_fwd_duty;
    logic [OUT_DUTY_W-1:0] right_rev_duty;
    logic [CLASS_W-1:0]    motion_class;
  } result_t;

endpackage

@@ rtl/dmrd_channels.sv @@
// Valid/ready channel interfaces for command beats and result beats.
// Depends on dmrd_pkg for field widths.
`timescale 1ns / 1ps

interface dmrd_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [dmrd_pkg::FUNC_W-1:0]         func;
  logic signed [dmrd_pkg::SPEED_W-1:0] left_request;
  logic signed [dmrd_pkg::SPEED_W-1:0] right_request;

  modport source (output valid, output func, output left_request, output right_request,
                  input ready);
  modport sink (input valid, input func, input left_request, input right_request,
                output ready);
endinterface

interface dmrd_res_if;
  logic                              valid;
  logic                              ready;
  logic [dmrd_pkg::OUT_DUTY_W-1:0]   left_fwd_duty;
  logic [dmrd_pkg::OUT_DUTY_W-1:0]   left_rev_duty;
  logic [dmrd_pkg::OUT_DUTY_W-1:0]   right_fwd_duty;
  logic [dmrd_pkg::OUT_DUTY_W-1:0]   right_rev_duty;
  logic [dmrd_pkg::CLASS_W-1:0]      motion_class;

  modport source (output valid, output left_fwd_duty, output left_rev_duty,
                  output right_fwd_duty, output right_rev_duty, output motion_class,
                  input ready);
  modport sink (input valid, input left_fwd_duty, input left_rev_duty,
                input right_fwd_duty, input right_rev_duty, input motion_class,
                output ready);
endinterface

@@ rtl/dual_motor_ramp_drive.sv @@
// Top level of the dual motor ramp drive: input register, update logic, result register.
// Depends on dmrd_pkg, dmrd_channels, dmrd_cfg and dmrd_step.
//
// Usage: command beats arrive on cmd. A set beat stores clamped left and right goals, a
// stop beat zeroes goals and speeds at once, and a tick beat stands for one millisecond
// and steps the speeds toward their goals once every ramp_interval ticks. Every command
// beat yields exactly one result beat on res with the forward and reverse duty of both
// bridges and the last refreshed motion class.
// After its command beat is accepted, a beat passes the input register and then the
// result register, leaving the input register only when the result register is free.
// One beat is accepted per cycle while cmd.ready is high; the state update of a beat is
// done as it moves from the input register to the result register.
// If res stalls, the result register holds its beat and the input register holds the
// next one; cmd.ready drops only when both are full. Configuration registers are written
// through cfg_write, cfg_index and cfg_data by the user only while no beat is in flight;
// the block does not enforce this. Synchronous reset clears the goals, speeds, interval
// counter, motion class and both registers' valid flags, and loads the register defaults.
`timescale 1ns / 1ps

module dual_motor_ramp_drive #(
  parameter int DUTY_BITS     = dmrd_pkg::DUTY_BITS_DEF,
  parameter int INTERVAL_BITS = dmrd_pkg::INTERVAL_BITS_DEF,
  parameter int CFG_W         = (DUTY_BITS > INTERVAL_BITS) ? DUTY_BITS : INTERVAL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  dmrd_cmd_if.sink                       cmd,
  dmrd_res_if.source                     res,
  input  logic                           cfg_write,
  input  logic [dmrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);

  logic [DUTY_BITS-1:0]                max_duty;
  logic [DUTY_BITS-1:0]                ramp_step;
  logic [INTERVAL_BITS-1:0]            ramp_interval;

  logic                                in_valid;
  logic [dmrd_pkg::FUNC_W-1:0]         in_func;
  logic signed [dmrd_pkg::SPEED_W-1:0] in_left_request;
  logic signed [dmrd_pkg::SPEED_W-1:0] in_right_request;

  logic                                out_valid;
  dmrd_pkg::result_t                   out_result;
  dmrd_pkg::result_t                   step_result;

  logic                                out_free;
  logic                                advance;

  assign out_free  = !out_valid || res.ready;
  assign advance   = in_valid && out_free;
  assign cmd.ready = !in_valid || advance;

  dmrd_cfg #(
    .DUTY_BITS     (DUTY_BITS),
    .INTERVAL_BITS (INTERVAL_BITS),
    .CFG_W         (CFG_W)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .max_duty      (max_duty),
    .ramp_step     (ramp_step),
    .ramp_interval (ramp_interval)
  );

  dmrd_step #(
    .DUTY_BITS     (DUTY_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_step (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .func          (in_func),
    .left_request  (in_left_request),
    .right_request (in_right_request),
    .max_duty      (max_duty),
    .ramp_step     (ramp_step),
    .ramp_interval (ramp_interval),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_func          <= cmd.func;
      in_left_request  <= cmd.left_request;
      in_right_request <= cmd.right_request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign res.valid          = out_valid;
  assign res.left_fwd_duty  = out_result.left_fwd_duty;
  assign res.left_rev_duty  = out_result.left_rev_duty;
  assign res.right_fwd_duty = out_result.right_fwd_duty;
  assign res.right_rev_duty = out_result.right_rev_duty;
  assign res.motion_class   = out_result.motion_class;

endmodule

@@ rtl/dmrd_cfg.sv @@
// Configuration registers of the dual motor ramp drive.
// Depends on dmrd_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module dmrd_cfg #(
  parameter int DUTY_BITS     = dmrd_pkg::DUTY_BITS_DEF,
  parameter int INTERVAL_BITS = dmrd_pkg::INTERVAL_BITS_DEF,
  parameter int CFG_W         = (DUTY_BITS > INTERVAL_BITS) ? DUTY_BITS : INTERVAL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dmrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  output logic [DUTY_BITS-1:0]           max_duty,
  output logic [DUTY_BITS-1:0]           ramp_step,
  output logic [INTERVAL_BITS-1:0]       ramp_interval
);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duty      <= DUTY_BITS'(dmrd_pkg::MAX_DUTY_RESET);
      ramp_step     <= DUTY_BITS'(dmrd_pkg::RAMP_STEP_RESET);
      ramp_interval <= INTERVAL_BITS'(dmrd_pkg::RAMP_INTERVAL_RESET);
    end else if (cfg_write) begin
      if (cfg_index == dmrd_pkg::REG_MAX_DUTY) begin
        max_duty <= cfg_data[DUTY_BITS-1:0];
      end
      if (cfg_index == dmrd_pkg::REG_RAMP_STEP) begin
        ramp_step <= cfg_data[DUTY_BITS-1:0];
      end
      if (cfg_index == dmrd_pkg::REG_RAMP_INTERVAL) begin
        ramp_interval <= cfg_data[INTERVAL_BITS-1:0];
      end
    end
  end

endmodule

@@ rtl/dmrd_step.sv @@
// Goal, speed, interval counter and class state with the per-beat update logic.
// Depends on dmrd_pkg for command codes, class codes and the result struct.
`timescale 1ns / 1ps

module dmrd_step #(
  parameter int DUTY_BITS     = dmrd_pkg::DUTY_BITS_DEF,
  parameter int INTERVAL_BITS = dmrd_pkg::INTERVAL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic [dmrd_pkg::FUNC_W-1:0]         func,
  input  logic signed [dmrd_pkg::SPEED_W-1:0] left_request,
  input  logic signed [dmrd_pkg::SPEED_W-1:0] right_request,
  input  logic [DUTY_BITS-1:0]                max_duty,
  input  logic [DUTY_BITS-1:0]                ramp_step,
  input  logic [INTERVAL_BITS-1:0]            ramp_interval,
  output dmrd_pkg::result_t                   result
);

  localparam int GW    = DUTY_BITS + 1;
  localparam int SW    = DUTY_BITS + 2;
  localparam int CW    = (DUTY_BITS + 2 > 17) ? DUTY_BITS + 2 : 17;
  localparam int MAG_W = (GW > dmrd_pkg::OUT_DUTY_W) ? GW : dmrd_pkg::OUT_DUTY_W;

  logic signed [GW-1:0]         left_goal, right_goal, left_now, right_now;
  logic [INTERVAL_BITS-1:0]     ms_since_step;
  logic [dmrd_pkg::CLASS_W-1:0] shown_class;

  logic signed [GW-1:0]         left_goal_next, right_goal_next;
  logic signed [GW-1:0]         left_now_next, right_now_next;
  logic [INTERVAL_BITS-1:0]     ms_since_step_next;
  logic [dmrd_pkg::CLASS_W-1:0] shown_class_next;
  logic [INTERVAL_BITS-1:0]     ms_inc;
  logic                         interval_hit;

  function automatic logic signed [GW-1:0] limit_goal(
    input logic signed [dmrd_pkg::SPEED_W-1:0] v,
    input logic [DUTY_BITS-1:0]                m
  );
    logic signed [CW-1:0] wv;
    logic signed [CW-1:0] pos;
    logic signed [CW-1:0] neg;
    wv  = CW'(v);
    pos = CW'($signed({1'b0, m}));
    neg = -pos;
    if (wv < neg) begin
      return GW'(neg);
    end else if (wv > pos) begin
      return GW'(pos);
    end
    return GW'(wv);
  endfunction

  function automatic logic signed [GW-1:0] move_toward(
    input logic signed [GW-1:0] cur,
    input logic signed [GW-1:0] goal,
    input logic [DUTY_BITS-1:0] step
  );
    logic signed [SW-1:0] wc;
    logic signed [SW-1:0] wg;
    logic signed [SW-1:0] ws;
    logic signed [SW-1:0] moved;
    wc    = SW'(cur);
    wg    = SW'(goal);
    ws    = SW'($signed({1'b0, step}));
    moved = wc;
    if (wc < wg) begin
      moved = wc + ws;
      if (moved > wg) begin
        moved = wg;
      end
    end else if (wc > wg) begin
      moved = wc - ws;
      if (moved < wg) begin
        moved = wg;
      end
    end
    return GW'(moved);
  endfunction

  function automatic logic [dmrd_pkg::CLASS_W-1:0] classify(
    input logic signed [GW-1:0] lg,
    input logic signed [GW-1:0] rg
  );
    priority if (lg == '0 && rg == '0) begin
      return dmrd_pkg::CLASS_STOP;
    end else if (lg > 0 && rg > 0) begin
      return dmrd_pkg::CLASS_FORWARD;
    end else if (lg < 0 && rg < 0) begin
      return dmrd_pkg::CLASS_BACKWARD;
    end else if (lg < 0 && rg > 0) begin
      return dmrd_pkg::CLASS_LEFT;
    end else if (lg > 0 && rg < 0) begin
      return dmrd_pkg::CLASS_RIGHT;
    end else begin
      return dmrd_pkg::CLASS_OTHER;
    end
  endfunction

  function automatic logic [dmrd_pkg::OUT_DUTY_W-1:0] fwd_of(input logic signed [GW-1:0] v);
    logic [MAG_W-1:0] mag;
    mag = MAG_W'(v);
    return (v > 0) ? mag[dmrd_pkg::OUT_DUTY_W-1:0] : '0;
  endfunction

  function automatic logic [dmrd_pkg::OUT_DUTY_W-1:0] rev_of(input logic signed [GW-1:0] v);
    logic signed [SW-1:0] neg;
    logic [MAG_W-1:0]     mag;
    neg = -SW'(v);
    mag = MAG_W'(neg);
    return (v < 0) ? mag[dmrd_pkg::OUT_DUTY_W-1:0] : '0;
  endfunction

  assign ms_inc       = (ms_since_step != {INTERVAL_BITS{1'b1}}) ? ms_since_step + 1'b1
                                                                 : ms_since_step;
  assign interval_hit = (ms_inc >= ramp_interval);

  always_comb begin
    left_goal_next     = left_goal;
    right_goal_next    = right_goal;
    left_now_next      = left_now;
    right_now_next     = right_now;
    ms_since_step_next = ms_since_step;
    shown_class_next   = shown_class;
    unique case (func)
      dmrd_pkg::FUNC_SET: begin
        left_goal_next  = limit_goal(left_request, max_duty);
        right_goal_next = limit_goal(right_request, max_duty);
      end
      dmrd_pkg::FUNC_STOP: begin
        left_goal_next   = '0;
        right_goal_next  = '0;
        left_now_next    = '0;
        right_now_next   = '0;
        shown_class_next = dmrd_pkg::CLASS_STOP;
      end
      dmrd_pkg::FUNC_TICK: begin
        ms_since_step_next = interval_hit ? '0 : ms_inc;
        if (interval_hit && (left_now != left_goal || right_now != right_goal)) begin
          left_now_next    = move_toward(left_now, left_goal, ramp_step);
          right_now_next   = move_toward(right_now, right_goal, ramp_step);
          shown_class_next = classify(left_goal, right_goal);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_goal     <= '0;
      right_goal    <= '0;
      left_now      <= '0;
      right_now     <= '0;
      ms_since_step <= '0;
      shown_class   <= dmrd_pkg::CLASS_STOP;
    end else if (advance) begin
      left_goal     <= left_goal_next;
      right_goal    <= right_goal_next;
      left_now      <= left_now_next;
      right_now     <= right_now_next;
      ms_since_step <= ms_since_step_next;
      shown_class   <= shown_class_next;
    end
  end

  always_comb begin
    result.left_fwd_duty  = fwd_of(left_now_next);
    result.left_rev_duty  = rev_of(left_now_next);
    result.right_fwd_duty = fwd_of(right_now_next);
    result.right_rev_duty = rev_of(right_now_next);
    result.motion_class   = shown_class_next;
  end

endmodule

@@ rtl/dmrd_checker.sv @@
// Port-level checks for the dual motor ramp drive, attached to the top level by bind.
// Depends on dmrd_pkg for widths and class codes.
`timescale 1ns / 1ps

module dmrd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cmd_valid,
  input logic                            cmd_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [dmrd_pkg::OUT_DUTY_W-1:0] left_fwd_duty,
  input logic [dmrd_pkg::OUT_DUTY_W-1:0] left_rev_duty,
  input logic [dmrd_pkg::OUT_DUTY_W-1:0] right_fwd_duty,
  input logic [dmrd_pkg::OUT_DUTY_W-1:0] right_rev_duty,
  input logic [dmrd_pkg::CLASS_W-1:0]    motion_class
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(left_fwd_duty)
      && $stable(left_rev_duty) && $stable(right_fwd_duty)
      && $stable(right_rev_duty) && $stable(motion_class))
    else $error("Stalled result beat changed.");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (left_fwd_duty == '0 || left_rev_duty == '0)
      && (right_fwd_duty == '0 || right_rev_duty == '0))
    else $error("A bridge is driven forward and reverse at once.");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> motion_class <= dmrd_pkg::CLASS_OTHER)
    else $error("Motion class out of range.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && cmd_ready)
    else $error("Block not empty after reset.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !cmd_valid && !$past(cmd_valid, 2) && !$past(res_valid) && !$past(rst) |-> !res_valid)
    else $error("Result beat without a command beat.");

endmodule

bind dual_motor_ramp_drive dmrd_checker u_dmrd_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .left_fwd_duty  (res.left_fwd_duty),
  .left_rev_duty  (res.left_rev_duty),
  .right_fwd_duty (res.right_fwd_duty),
  .right_rev_duty (res.right_rev_duty),
  .motion_class   (res.motion_class)
);
